FILE: design/mahd_pkg.sv
// Shared types, field codes and the Layer III frame-size table for the
// MPEG audio header decoder. No dependencies.

package mahd_pkg;

  localparam int unsigned HeaderWidth = 32;
  localparam int unsigned SizeWidth   = 11;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  localparam logic [11:0] SYNC_PATTERN  = 12'hfff;
  localparam logic [1:0]  LAYER_RSVD    = 2'b00;
  localparam logic [1:0]  LAYER_III     = 2'b01;
  localparam logic [1:0]  RATE_RSVD     = 2'b11;
  localparam logic [3:0]  BR_FREE       = 4'd0;
  localparam logic [3:0]  BR_BAD        = 4'd15;
  localparam logic [1:0]  MODE_MONO     = 2'b11;
  localparam logic [2:0]  LSF_RATE_OFFS = 3'd3;

  localparam logic [2:0] RIDX_44100 = 3'd0;
  localparam logic [2:0] RIDX_48000 = 3'd1;
  localparam logic [2:0] RIDX_32000 = 3'd2;
  localparam logic [2:0] RIDX_22050 = 3'd3;
  localparam logic [2:0] RIDX_24000 = 3'd4;
  localparam logic [2:0] RIDX_16000 = 3'd5;

  // Decoded header, everything except the frame size.
  typedef struct packed {
    logic       status;
    logic       sync_ok;
    logic       low_rate_ext;
    logic [2:0] rate_index;
    logic [3:0] bitrate_code;
    logic       crc_present;
    logic       pad_bit;
    logic [1:0] channel_mode;
    logic [1:0] mode_extension;
    logic [1:0] channel_count;
    logic [4:0] misc_flags;
  } mahd_hdr_t;

  typedef logic [SizeWidth-1:0] mahd_size_t;

  // Frame bytes after the header, no padding: kbps*144000/rate - 4, or kbps*72000/rate - 4 at the LSF rates.
  // Indexed by bitrate code; codes 0 and 15 are errors and read 0.
  localparam mahd_size_t SIZE_44100 [16] = '{
    11'd0,   11'd100, 11'd126, 11'd152, 11'd178, 11'd204, 11'd257, 11'd309,
    11'd361, 11'd413, 11'd518, 11'd622, 11'd727, 11'd831, 11'd1040, 11'd0
  };
  localparam mahd_size_t SIZE_48000 [16] = '{
    11'd0,   11'd92,  11'd116, 11'd140, 11'd164, 11'd188, 11'd236, 11'd284,
    11'd332, 11'd380, 11'd476, 11'd572, 11'd668, 11'd764, 11'd956, 11'd0
  };
  localparam mahd_size_t SIZE_32000 [16] = '{
    11'd0,   11'd140, 11'd176, 11'd212, 11'd248, 11'd284, 11'd356, 11'd428,
    11'd500, 11'd572, 11'd716, 11'd860, 11'd1004, 11'd1148, 11'd1436, 11'd0
  };
  localparam mahd_size_t SIZE_22050 [16] = '{
    11'd0,   11'd22,  11'd48,  11'd74,  11'd100, 11'd126, 11'd152, 11'd178,
    11'd204, 11'd257, 11'd309, 11'd361, 11'd413, 11'd466, 11'd518, 11'd0
  };
  localparam mahd_size_t SIZE_24000 [16] = '{
    11'd0,   11'd20,  11'd44,  11'd68,  11'd92,  11'd116, 11'd140, 11'd164,
    11'd188, 11'd236, 11'd284, 11'd332, 11'd380, 11'd428, 11'd476, 11'd0
  };
  localparam mahd_size_t SIZE_16000 [16] = '{
    11'd0,   11'd32,  11'd68,  11'd104, 11'd140, 11'd176, 11'd212, 11'd248,
    11'd284, 11'd356, 11'd428, 11'd500, 11'd572, 11'd644, 11'd716, 11'd0
  };

  function automatic mahd_size_t frame_base(logic [2:0] ridx, logic [3:0] br);
    mahd_size_t res;
    case (ridx)
      RIDX_44100: res = SIZE_44100[br];
      RIDX_48000: res = SIZE_48000[br];
      RIDX_32000: res = SIZE_32000[br];
      RIDX_22050: res = SIZE_22050[br];
      RIDX_24000: res = SIZE_24000[br];
      RIDX_16000: res = SIZE_16000[br];
      default:    res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/mahd_front.sv
// Front stage: accepts header words, unpacks and classifies them into a
// registered mahd_hdr_t. Depends on mahd_pkg.

module mahd_front import mahd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [HeaderWidth-1:0] header_word_i,
  output logic                   hdr_valid_o,
  input  logic                   hdr_ready_i,
  output mahd_hdr_t              hdr_o
);

  logic       valid_q, valid_d;
  mahd_hdr_t  hdr_q, hdr_d;

  logic [1:0] layer_bits;
  logic [3:0] br;
  logic [1:0] sr;
  logic       lsf;
  logic       v1_or_2;
  logic [1:0] mode;

  assign layer_bits = header_word_i[18:17];
  assign br         = header_word_i[15:12];
  assign sr         = header_word_i[11:10];
  assign lsf        = ~header_word_i[19];
  assign v1_or_2    = header_word_i[20];
  assign mode       = header_word_i[7:6];

  assign in_ready_o = ~valid_q | hdr_ready_i;

  always_comb begin
    hdr_d.sync_ok = (header_word_i[31:20] == SYNC_PATTERN) && (layer_bits != LAYER_RSVD) &&
                    (br != BR_BAD) && (sr != RATE_RSVD);
    hdr_d.status  = ~v1_or_2 || (sr == RATE_RSVD) || (br == BR_FREE) || (br == BR_BAD) ||
                    (layer_bits != LAYER_III);
    hdr_d.low_rate_ext = lsf;
    if (v1_or_2 && (sr != RATE_RSVD)) begin
      hdr_d.rate_index = {1'b0, sr} + (lsf ? LSF_RATE_OFFS : 3'd0);
    end else begin
      hdr_d.rate_index = RIDX_44100;
    end
    hdr_d.bitrate_code   = br;
    hdr_d.crc_present    = ~header_word_i[16];
    hdr_d.pad_bit        = header_word_i[9];
    hdr_d.channel_mode   = mode;
    hdr_d.mode_extension = header_word_i[5:4];
    hdr_d.channel_count  = (mode == MODE_MONO) ? 2'd1 : 2'd2;
    hdr_d.misc_flags     = {header_word_i[8], header_word_i[3:2], header_word_i[1:0]};
  end

  assign valid_d = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads on every transfer into the stage.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hdr_q <= hdr_d;
    end
  end

  assign hdr_valid_o = valid_q;
  assign hdr_o       = hdr_q;

endmodule

FILE: design/mahd_queue.sv
// Short queue between the front and back stages so each side can stall
// on its own. Depends on mahd_pkg.

module mahd_queue import mahd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  mahd_hdr_t wr_data_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output mahd_hdr_t rd_data_o
);

  mahd_hdr_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wptr_q, wptr_d;
  logic [QueuePtrW-1:0]  rptr_q, rptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  push, pop;

  assign wr_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];

  assign push = wr_valid_i & wr_ready_o;
  assign pop  = rd_valid_o & rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: design/mahd_back.sv
// Back stage: looks up the Layer III frame size, adds padding and holds
// the finished result in the output register. Depends on mahd_pkg.

module mahd_back import mahd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hdr_valid_i,
  output logic       hdr_ready_o,
  input  mahd_hdr_t  hdr_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output mahd_hdr_t  res_hdr_o,
  output mahd_size_t res_size_o
);

  logic       valid_q, valid_d;
  mahd_hdr_t  hdr_q;
  mahd_size_t size_q, size_d;

  assign hdr_ready_o = ~valid_q | res_ready_i;
  assign valid_d     = hdr_ready_o ? hdr_valid_i : valid_q;

  // Errored headers report a zero size.
  always_comb begin
    if (hdr_i.status) begin
      size_d = '0;
    end else begin
      size_d = frame_base(hdr_i.rate_index, hdr_i.bitrate_code) +
               SizeWidth'(hdr_i.pad_bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_valid_i && hdr_ready_o) begin
      hdr_q  <= hdr_i;
      size_q <= size_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_hdr_o   = hdr_q;
  assign res_size_o  = size_q;

endmodule

FILE: design/mpeg_audio_header_decoder_unit.sv
// MPEG audio Layer III frame header decoder, top level.
// Instantiates mahd_front, mahd_queue and mahd_back; depends on mahd_pkg.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one 32-bit header word
//   (first received byte in bits 31..24). Output channel out_valid_o/
//   out_ready_i carries one result per header: unpacked fields, a sync
//   check, an error status and the frame size in bytes after the header
//   (zero on error).
//   out_valid_o rises once an input transfer has passed the front register,
//   the two-entry queue and the back output register.
//   Throughput is one header per cycle while out_ready_i stays high; the
//   frame-size lookup is a constant table read in the back stage, so
//   nothing iterates.
//   When the receiver stalls, the output register holds its result, the
//   queue fills, and in_ready_o drops only once the front register, queue
//   and output register are all occupied (four headers in flight).
//   Reset empties all stages; the block can take input once rst_ni rises.

module mpeg_audio_header_decoder_unit import mahd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [HeaderWidth-1:0] header_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   status_o,
  output logic                   sync_ok_o,
  output logic                   low_rate_ext_o,
  output logic [2:0]             rate_index_o,
  output logic [3:0]             bitrate_code_o,
  output logic                   crc_present_o,
  output logic                   pad_bit_o,
  output logic [1:0]             channel_mode_o,
  output logic [1:0]             mode_extension_o,
  output logic [1:0]             channel_count_o,
  output logic [4:0]             misc_flags_o,
  output logic [SizeWidth-1:0]   frame_size_o
);

  logic       fr_valid, fr_ready;
  mahd_hdr_t  fr_hdr;
  logic       q_valid, q_ready;
  mahd_hdr_t  q_hdr;
  mahd_hdr_t  res_hdr;
  mahd_size_t res_size;

  mahd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .header_word_i (header_word_i),
    .hdr_valid_o   (fr_valid),
    .hdr_ready_i   (fr_ready),
    .hdr_o         (fr_hdr)
  );

  mahd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_hdr),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_hdr)
  );

  mahd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdr_valid_i (q_valid),
    .hdr_ready_o (q_ready),
    .hdr_i       (q_hdr),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_hdr_o   (res_hdr),
    .res_size_o  (res_size)
  );

  assign status_o         = res_hdr.status;
  assign sync_ok_o        = res_hdr.sync_ok;
  assign low_rate_ext_o   = res_hdr.low_rate_ext;
  assign rate_index_o     = res_hdr.rate_index;
  assign bitrate_code_o   = res_hdr.bitrate_code;
  assign crc_present_o    = res_hdr.crc_present;
  assign pad_bit_o        = res_hdr.pad_bit;
  assign channel_mode_o   = res_hdr.channel_mode;
  assign mode_extension_o = res_hdr.mode_extension;
  assign channel_count_o  = res_hdr.channel_count;
  assign misc_flags_o     = res_hdr.misc_flags;
  assign frame_size_o     = res_size;

endmodule
